// ----- rtl/smt_pkg.sv -----
// Package with the types, constants and codes shared by the Sobel magnitude block.
package smt_pkg;

    // Line store depth and the widths that follow from it.
    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WID_W     = $clog2(MAX_WIDTH + 1);

    // Field and register widths.
    localparam int PIX_W      = 8;
    localparam int THR_W      = 8;
    localparam int FW_W       = 11;
    localparam int FH_W       = 12;
    localparam int ROW_W      = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int CMP_W      = (WID_W > FW_W) ? WID_W : FW_W;

    // Arithmetic widths: gradients are within +/-1020, squares below 2^20.
    localparam int GRAD_W = 11;
    localparam int SQ_W   = 20;
    localparam int SUM_W  = 21;
    localparam int ROOT_W = 8;
    localparam int RAD_W  = 16;

    // Smallest frame dimension and reset geometry.
    localparam int MIN_DIM        = 3;
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int BORDER         = 2;
    localparam int ROOT_STEPS     = 8;
    localparam int STEP_W         = $clog2(ROOT_STEPS);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD  = 2'd0,
        REG_ROW_PIXELS = 2'd1,
        REG_ROW_COUNT  = 2'd2
    } t_cfg_reg;

    // Sequencer states of the top level.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_SQR,
        S_START,
        S_ROOT,
        S_EMIT
    } t_state;

    // Context of the pixel being worked on.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [COL_W-1:0] col;
        logic             last;
        logic             emit;
    } t_item;

    // Status returned by the square root unit.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_root_stat;

endpackage

// ----- rtl/smt_if.sv -----
// Valid/ready channel interfaces for pixels, results and configuration writes.
interface smt_pix_if import smt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;
    logic             frame_start;

    modport source (output valid, output pixel, output frame_start, input ready);
    modport sink (input valid, input pixel, input frame_start, output ready);
endinterface

interface smt_res_if import smt_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] edge_value;
    logic             frame_last;

    modport source (output valid, output edge_value, output frame_last, input ready);
    modport sink (input valid, input edge_value, input frame_last, output ready);
endinterface

interface smt_cfg_if import smt_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/smt_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
module smt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/smt_isqrt.sv -----
// Iterative integer square root, one result bit per cycle, saturated to 255.
module smt_isqrt import smt_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_value,
    output t_root_stat       o_stat
);

    logic [RAD_W-1:0]  r_op;
    logic [RAD_W-1:0]  r_res;
    logic [RAD_W-1:0]  r_one;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [RAD_W:0]    w_trial;
    logic              w_fits;

    // One step of the restoring square root: try the next result bit.
    assign w_trial = {1'b0, r_res} + {1'b0, r_one};
    assign w_fits  = {1'b0, r_op} >= w_trial;

    // Control: busy while the root steps run, then a one-cycle done.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == STEP_W'(ROOT_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath. Inputs of 2^16 and above use the largest 16-bit value,
    // whose root is 255, which gives the saturation.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_op  <= (i_value[SUM_W-1:RAD_W] != '0) ? '1 : i_value[RAD_W-1:0];
            r_res <= '0;
            r_one <= RAD_W'(1) << (RAD_W - 2);
        end else if (r_busy) begin
            if (w_fits) begin
                r_op  <= r_op - w_trial[RAD_W-1:0];
                r_res <= (r_res >> 1) + r_one;
            end else begin
                r_res <= r_res >> 1;
            end
            r_one <= r_one >> 2;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_stat.root = r_res[ROOT_W-1:0];

    // A new root is started only while the unit is free.
    a_start_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("square root started while busy");

    // Done follows the last busy cycle.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && !r_busy)
        else $error("square root done without a preceding busy cycle");

    // The result never exceeds eight bits of magnitude.
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_res[RAD_W-1:ROOT_W] == '0)
        else $error("square root result out of range");

endmodule

// ----- rtl/sobel_magnitude_threshold.sv -----
// Top level of the streaming Sobel gradient magnitude with threshold.
//
//   Port    Dir   Transaction payload
//   i_pix   in    pixel[7:0], frame_start
//   o_res   out   edge_value[7:0], frame_last
//   i_cfg   in    index[1:0] (0 threshold, 1 row pixels, 2 row count), data[11:0]
//
// A pixel without a result is accepted and then written back; a pixel with a result then
// goes on through squaring, the 8-step iterative square root and the emit state.
// One pixel is in work at a time; the line stores are read and written back per pixel.
// Reset (synchronous, active low) clears position, window, sequencer and registers.
// A finished result waits in the output register while the next pixel is taken;
// only a new result stalls until that register has been taken.
module sobel_magnitude_threshold import smt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    smt_pix_if.sink   i_pix,
    smt_res_if.source o_res,
    smt_cfg_if.sink   i_cfg
);

    // Configuration registers.
    logic [THR_W-1:0] r_thresh;
    logic [FW_W-1:0]  r_fw;
    logic [FH_W-1:0]  r_fh;

    // Position and sequencer.
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    t_state           r_state;
    t_state           n_state;
    t_item            r_item;

    // Window: columns two back and one back of rows top, middle, bottom.
    logic [PIX_W-1:0] r_win [6];

    // Gradient and squares.
    logic signed [GRAD_W-1:0]   r_gx;
    logic signed [GRAD_W-1:0]   r_gy;
    logic [SQ_W-1:0]            r_gx2;
    logic [SQ_W-1:0]            r_gy2;
    logic signed [2*GRAD_W-1:0] w_gx2;
    logic signed [2*GRAD_W-1:0] w_gy2;
    logic [SUM_W-1:0]           w_sum;

    // Thresholded magnitude and output register.
    logic [PIX_W-1:0] r_edge;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_edge;
    logic             r_out_last;

    // Effective geometry and position of an incoming pixel.
    logic [CMP_W-1:0] w_fw_cmp;
    logic [WID_W-1:0] w_ew;
    logic [FH_W-1:0]  w_eh;
    logic [WID_W-1:0] w_c0;
    logic [ROW_W:0]   w_r0;
    logic [WID_W-1:0] w_c1;
    logic [ROW_W:0]   w_r1;
    logic [COL_W-1:0] w_c;
    logic [ROW_W-1:0] w_r;
    logic [WID_W-1:0] w_cn;
    logic [ROW_W:0]   w_rn;
    logic [COL_W-1:0] w_col_next;
    logic [ROW_W-1:0] w_row_next;
    logic             w_last;
    logic             w_emit;

    // Control and memory signals.
    logic             w_pix_acc;
    logic             w_ram_we;
    logic             w_isq_start;
    logic             w_out_load;
    logic [PIX_W-1:0] w_top;
    logic [PIX_W-1:0] w_mid;
    logic [PIX_W-1:0] w_edge;
    t_root_stat       w_root;

    // Window taps as signed gradient operands.
    logic signed [GRAD_W-1:0] w_tl, w_ml, w_bl, w_tc, w_bc, w_tr, w_mr, w_br;

    // Configuration writes are taken whenever the block is out of reset.
    assign i_cfg.ready = i_rst_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= '0;
            r_fw     <= FW_W'(RESET_WIDTH);
            r_fh     <= FH_W'(RESET_HEIGHT);
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_THRESHOLD:  r_thresh <= i_cfg.data[THR_W-1:0];
                REG_ROW_PIXELS: r_fw     <= i_cfg.data[FW_W-1:0];
                REG_ROW_COUNT:  r_fh     <= i_cfg.data[FH_W-1:0];
                default: ;
            endcase
        end
    end

    // Width clamped to 3..MAX_WIDTH, height raised to at least 3.
    assign w_fw_cmp = CMP_W'(r_fw);
    always_comb begin
        if (w_fw_cmp < CMP_W'(MIN_DIM)) begin
            w_ew = WID_W'(MIN_DIM);
        end else if (w_fw_cmp > CMP_W'(MAX_WIDTH)) begin
            w_ew = WID_W'(MAX_WIDTH);
        end else begin
            w_ew = w_fw_cmp[WID_W-1:0];
        end
    end
    assign w_eh = (r_fh < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : r_fh;

    // Position of the incoming pixel, with wrap for a lowered geometry.
    always_comb begin
        w_c0 = i_pix.frame_start ? '0 : WID_W'(r_col);
        w_r0 = i_pix.frame_start ? '0 : {1'b0, r_row};
        if (w_c0 >= w_ew) begin
            w_c1 = '0;
            w_r1 = w_r0 + 1'b1;
        end else begin
            w_c1 = w_c0;
            w_r1 = w_r0;
        end
        if (w_r1 >= {1'b0, w_eh}) begin
            w_r = '0;
        end else begin
            w_r = w_r1[ROW_W-1:0];
        end
        w_c = w_c1[COL_W-1:0];
    end

    // Position after this pixel.
    always_comb begin
        w_cn = WID_W'(w_c) + 1'b1;
        w_rn = {1'b0, w_r};
        if (w_cn >= w_ew) begin
            w_col_next = '0;
            w_rn       = {1'b0, w_r} + 1'b1;
        end else begin
            w_col_next = w_cn[COL_W-1:0];
        end
        if (w_rn >= {1'b0, w_eh}) begin
            w_row_next = '0;
        end else begin
            w_row_next = w_rn[ROW_W-1:0];
        end
    end

    assign w_last = (w_r == w_eh - 1'b1) && (WID_W'(w_c) == w_ew - 1'b1);
    assign w_emit = (w_r >= ROW_W'(BORDER)) && (w_c >= COL_W'(BORDER));

    // Position counters and item context, loaded when a pixel is accepted.
    assign w_pix_acc = i_pix.valid && i_pix.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_pix_acc) begin
            r_col <= w_col_next;
            r_row <= w_row_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pix_acc) begin
            r_item.pixel <= i_pix.pixel;
            r_item.col   <= w_c;
            r_item.last  <= w_last;
            r_item.emit  <= w_emit;
        end
    end

    // Line stores: read at acceptance, written back in the following cycle.
    smt_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_above (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_item.col),
        .i_wdata (r_item.pixel),
        .i_raddr (w_c),
        .o_rdata (w_mid)
    );

    smt_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_two_above (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (r_item.col),
        .i_wdata (w_mid),
        .i_raddr (w_c),
        .o_rdata (w_top)
    );

    // Gradient operands from the window and the column just read.
    assign w_tl = $signed({3'b000, r_win[0]});
    assign w_ml = $signed({3'b000, r_win[1]});
    assign w_bl = $signed({3'b000, r_win[2]});
    assign w_tc = $signed({3'b000, r_win[3]});
    assign w_bc = $signed({3'b000, r_win[5]});
    assign w_tr = $signed({3'b000, w_top});
    assign w_mr = $signed({3'b000, w_mid});
    assign w_br = $signed({3'b000, r_item.pixel});

    // Window shift and gradients in the write-back cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (w_ram_we) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= w_top;
            r_win[4] <= w_mid;
            r_win[5] <= r_item.pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ram_we) begin
            r_gx <= (w_tl - w_tr) + ((w_ml - w_mr) <<< 1) + (w_bl - w_br);
            r_gy <= (w_tl - w_bl) + ((w_tc - w_bc) <<< 1) + (w_tr - w_br);
        end
    end

    // Squares, registered before the sum enters the square root.
    assign w_gx2 = r_gx * r_gx;
    assign w_gy2 = r_gy * r_gy;

    always_ff @(posedge i_clk) begin
        if (r_state == S_SQR) begin
            r_gx2 <= w_gx2[SQ_W-1:0];
            r_gy2 <= w_gy2[SQ_W-1:0];
        end
    end

    assign w_sum = {1'b0, r_gx2} + {1'b0, r_gy2};

    smt_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_isq_start),
        .i_value (w_sum),
        .o_stat  (w_root)
    );

    // Sequencer state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and control outputs.
    always_comb begin
        n_state      = r_state;
        i_pix.ready  = 1'b0;
        w_ram_we     = 1'b0;
        w_isq_start  = 1'b0;
        w_out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                i_pix.ready = i_rst_n;
                if (i_pix.valid) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                w_ram_we = 1'b1;
                n_state  = r_item.emit ? S_SQR : S_IDLE;
            end
            S_SQR: begin
                n_state = S_START;
            end
            S_START: begin
                w_isq_start = 1'b1;
                n_state     = S_ROOT;
            end
            S_ROOT: begin
                if (w_root.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || o_res.ready) begin
                    w_out_load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Threshold: the magnitude passes only when strictly greater.
    always_ff @(posedge i_clk) begin
        if (w_root.done) begin
            r_edge <= (w_root.root > r_thresh) ? w_root.root : '0;
        end
    end
    assign w_edge = r_edge;

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_edge <= w_edge;
            r_out_last <= r_item.last;
        end
    end

    assign o_res.valid      = r_out_valid;
    assign o_res.edge_value = r_out_edge;
    assign o_res.frame_last = r_out_last;

    // The write-back cycle always follows an accepted pixel.
    a_calc_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CALC |-> $past(w_pix_acc))
        else $error("write-back without an accepted pixel");

    // A root is only delivered while the sequencer waits for it.
    a_root_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_root.done |-> r_state == S_ROOT)
        else $error("square root finished outside its wait state");

    // A pending result holds the sequencer until the output register frees up.
    a_emit_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_EMIT && r_out_valid && !o_res.ready |=> r_state == S_EMIT)
        else $error("result dropped while the output register was full");

    // Only interior pixels reach the square root.
    a_interior_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_isq_start |-> r_item.emit)
        else $error("square root started for a border pixel");

endmodule
